// ===== design/multi_phase_current_ramp_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-phase current ramp generator
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_PHASE_CURRENT_RAMP_MACROS_SVH
`define MULTI_PHASE_CURRENT_RAMP_MACROS_SVH

`ifndef SYNTHESIS
`define MCR_ASSERT_CLKRST(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define MCR_ASSERT(lbl, prop, msg) `MCR_ASSERT_CLKRST(lbl, clk, rst_n, prop, msg)
`else
`define MCR_ASSERT_CLKRST(lbl, ck, rn, prop, msg)
`define MCR_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== design/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-phase current ramp package
// Request codes, table field codes and the table read-data types.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_WRITE   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [3:0] FS_KIND  = 4'd0;
    localparam logic [3:0] FS_RAMP  = 4'd1;
    localparam logic [3:0] FS_HOLD  = 4'd2;
    localparam logic [3:0] FS_FINAL = 4'd3;
    localparam logic [3:0] FS_STEP  = 4'd6;
    localparam logic [3:0] FS_REM   = 4'd9;
    localparam logic [3:0] FS_SIGN  = 4'd12;
    localparam logic [3:0] FS_LAST  = 4'd14;

    localparam int LANES = 3;

    localparam logic [31:0] TICK_CAP = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] ramp_len;
        logic [31:0] hold_len;
    } phase_rd_t;

    typedef struct packed {
        logic signed [15:0] final_val;
        logic signed [31:0] step;
        logic [31:0]        rem;
        logic signed [1:0]  rem_sign;
    } lane_rd_t;

endpackage

// ===== design/multi_phase_current_ramp.sv =====
// ----------------------------------------------------------------------------
// Multi-phase current ramp generator
// Startup setpoint generator: speed, d- and q-current follow a phase table.
// ----------------------------------------------------------------------------
// The input stream carries one request per word, selected by s_tuser: a tick,
// a write of one phase table field, or a restart of the profile. Only a tick
// produces an output word, carrying the three Q15 setpoints, the phase index
// and the valid and done flags. The phase count register sits on the APB port.
// A tick reads the phase table memory at the current phase in its accept
// cycle and updates the profile state in the update stage, when the output
// word is loaded; m_tvalid rises when the update stage fires into the output
// register. No new word is accepted while a tick waits in the update stage.
// Writes and restarts are taken one per cycle while no tick waits there, and
// may arrive back to back. A tick may be accepted while the previous output
// word still waits; when m_tready stays low the tick then waits in the update
// stage and s_tready drops until the output register frees. Reset clears the
// phase count, the profile state and the output valid; table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
`include "multi_phase_current_ramp_macros.svh"

module multi_phase_current_ramp #(
    parameter int MAX_PHASES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // entry_index, field_select, field_value, zero pad
    input  logic [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // speed_cmd, id_cmd, iq_cmd, phase_now, zero pad
    output logic [1:0]  m_tuser,  // profile_valid, profile_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam logic [3:0] COUNT_CAP = (MAX_PHASES > 15) ? 4'd15 : 4'(MAX_PHASES);

    logic [3:0]         cfg_reg;
    logic [3:0]         phase_reg;
    logic               begun_reg;
    logic               done_reg;
    logic [31:0]        tick_reg;
    logic signed [15:0] val_reg [mcr_pkg::LANES];
    logic [31:0]        acc_reg [mcr_pkg::LANES];
    logic               s1_valid_reg;
    logic [3:0]         s1_phase_reg;
    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    logic [1:0]         req;
    logic [2:0]         entry;
    logic [3:0]         sel;
    logic [31:0]        value;
    logic               accept;
    logic [3:0]         count;
    logic [3:0]         p_clamp;
    logic               wr_en;
    logic               rd_en;
    mcr_pkg::phase_rd_t phase_rd;
    mcr_pkg::lane_rd_t  lane_rd [mcr_pkg::LANES];

    logic               s1_fire;
    logic               active;
    logic [31:0]        tick0;
    logic [31:0]        ramp;
    logic [31:0]        hold;
    logic [31:0]        total;
    logic [31:0]        tick1;
    logic               at_final;
    logic               phase_end;
    logic               more;
    logic               advance;
    logic [31:0]        acc0  [mcr_pkg::LANES];
    logic signed [15:0] val_n [mcr_pkg::LANES];
    logic [31:0]        acc_n [mcr_pkg::LANES];
    logic signed [15:0] out_val [mcr_pkg::LANES];
    logic [3:0]         phase_next;
    logic               done_next;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, cfg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= 4'd0;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            cfg_reg <= pwdata[3:0];
        end
    end

    // Input decode and table access
    assign req      = s_tuser;
    assign entry    = s_tdata[2:0];
    assign sel      = s_tdata[6:3];
    assign value    = s_tdata[38:7];
    assign s_tready = !s1_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign count    = (cfg_reg > COUNT_CAP) ? COUNT_CAP : cfg_reg;
    assign p_clamp  = (phase_reg >= count) ? count - 4'd1 : phase_reg;
    assign wr_en    = accept && (req == mcr_pkg::REQ_WRITE) && (int'(entry) < MAX_PHASES)
                      && (sel <= mcr_pkg::FS_LAST);
    assign rd_en    = accept && (req == mcr_pkg::REQ_TICK);

    mcr_table #(
        .MAX_PHASES (MAX_PHASES),
        .AW         (AW)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (AW'(entry)),
        .wr_sel   (sel),
        .wr_value (value),
        .rd_en    (rd_en),
        .rd_addr  (AW'(p_clamp)),
        .phase_rd (phase_rd),
        .lane_rd  (lane_rd)
    );

    // Update stage
    assign s1_fire = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign active  = (count != 4'd0);

    always_comb
    begin
        tick0     = begun_reg ? tick_reg : 32'd0;
        ramp      = (phase_rd.ramp_len == 32'd0) ? 32'd1 : phase_rd.ramp_len;
        hold      = phase_rd.kind ? phase_rd.hold_len : 32'd0;
        total     = ((mcr_pkg::TICK_CAP - ramp) < hold) ? mcr_pkg::TICK_CAP : ramp + hold;
        tick1     = (tick0 < total) ? tick0 + 32'd1 : tick0;
        at_final  = (tick1 >= ramp);
        phase_end = (tick1 >= total);
        more      = ({1'b0, s1_phase_reg} + 5'd1) < {1'b0, count};
        advance   = phase_end && more;
        phase_next = advance ? s1_phase_reg + 4'd1 : s1_phase_reg;
        done_next  = (phase_end && !more) || (begun_reg && done_reg);
    end

    for (genvar k = 0; k < mcr_pkg::LANES; k++)
    begin : g_ch
        assign acc0[k]    = begun_reg ? acc_reg[k] : 32'd0;
        assign out_val[k] = active ? val_n[k] : val_reg[k];

        mcr_lane u_lane (
            .lane_rd  (lane_rd[k]),
            .cur_val  (val_reg[k]),
            .cur_acc  (acc0[k]),
            .ramp     (ramp),
            .at_final (at_final),
            .val_out  (val_n[k]),
            .acc_out  (acc_n[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 4'd0;
            phase_reg    <= 4'd0;
            begun_reg    <= 1'b0;
            done_reg     <= 1'b0;
            tick_reg     <= 32'd0;
            for (int k = 0; k < mcr_pkg::LANES; k++)
            begin
                val_reg[k] <= 16'sd0;
                acc_reg[k] <= 32'd0;
            end
        end
        else
        begin
            if (rd_en)
            begin
                s1_valid_reg <= 1'b1;
                s1_phase_reg <= p_clamp;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (accept && (req == mcr_pkg::REQ_RESTART))
            begin
                phase_reg <= 4'd0;
                begun_reg <= 1'b0;
                done_reg  <= 1'b0;
                tick_reg  <= 32'd0;
                for (int k = 0; k < mcr_pkg::LANES; k++)
                begin
                    val_reg[k] <= 16'sd0;
                    acc_reg[k] <= 32'd0;
                end
            end
            else if (s1_fire && active)
            begin
                phase_reg <= phase_next;
                begun_reg <= 1'b1;
                done_reg  <= done_next;
                tick_reg  <= advance ? 32'd0 : tick1;
                for (int k = 0; k < mcr_pkg::LANES; k++)
                begin
                    val_reg[k] <= val_n[k];
                    acc_reg[k] <= advance ? 32'd0 : acc_n[k];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            m_tdata_reg <= {5'd0,
                            active ? phase_next[2:0] : phase_reg[2:0],
                            out_val[2], out_val[1], out_val[0]};
            m_tuser_reg <= {active ? done_next : done_reg, active};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `MCR_ASSERT(a_tick_enters_update, (rd_en |=> s1_valid_reg), "tick did not reach update stage")
    `MCR_ASSERT(a_idle_profile_clear, (!begun_reg |-> (tick_reg == 32'd0) && !done_reg), "profile state set before first tick")
    `MCR_ASSERT(a_out_from_update, ($rose(m_tvalid_reg) |-> $past(s1_valid_reg)), "output word without a tick")

endmodule

// ===== design/mcr_table.sv =====
// ----------------------------------------------------------------------------
// Phase table
// Synchronous memories for the per-phase and per-channel profile fields,
// written one field per word and read one phase per cycle.
// ----------------------------------------------------------------------------
module mcr_table #(
    parameter int MAX_PHASES = 8,
    parameter int AW         = 3
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [3:0]           wr_sel,
    input  logic [31:0]          wr_value,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output mcr_pkg::phase_rd_t   phase_rd,
    output mcr_pkg::lane_rd_t    lane_rd [mcr_pkg::LANES]
);

    logic        kind_mem [MAX_PHASES];
    logic [31:0] ramp_mem [MAX_PHASES];
    logic [31:0] hold_mem [MAX_PHASES];

    mcr_pkg::phase_rd_t phase_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_sel == mcr_pkg::FS_KIND))
        begin
            kind_mem[wr_addr] <= wr_value[0];
        end
        if (wr_en && (wr_sel == mcr_pkg::FS_RAMP))
        begin
            ramp_mem[wr_addr] <= wr_value;
        end
        if (wr_en && (wr_sel == mcr_pkg::FS_HOLD))
        begin
            hold_mem[wr_addr] <= wr_value;
        end
        if (rd_en)
        begin
            phase_rd_reg.kind     <= kind_mem[rd_addr];
            phase_rd_reg.ramp_len <= ramp_mem[rd_addr];
            phase_rd_reg.hold_len <= hold_mem[rd_addr];
        end
    end

    assign phase_rd = phase_rd_reg;

    for (genvar l = 0; l < mcr_pkg::LANES; l++)
    begin : g_lane
        logic signed [15:0] final_mem [MAX_PHASES];
        logic signed [31:0] step_mem  [MAX_PHASES];
        logic [31:0]        rem_mem   [MAX_PHASES];
        logic signed [1:0]  sign_mem  [MAX_PHASES];
        mcr_pkg::lane_rd_t  lane_rd_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_sel == mcr_pkg::FS_FINAL + 4'(l)))
            begin
                final_mem[wr_addr] <= wr_value[15:0];
            end
            if (wr_en && (wr_sel == mcr_pkg::FS_STEP + 4'(l)))
            begin
                step_mem[wr_addr] <= wr_value;
            end
            if (wr_en && (wr_sel == mcr_pkg::FS_REM + 4'(l)))
            begin
                rem_mem[wr_addr] <= wr_value;
            end
            if (wr_en && (wr_sel == mcr_pkg::FS_SIGN + 4'(l)))
            begin
                sign_mem[wr_addr] <= wr_value[1:0];
            end
            if (rd_en)
            begin
                lane_rd_reg.final_val <= final_mem[rd_addr];
                lane_rd_reg.step      <= step_mem[rd_addr];
                lane_rd_reg.rem       <= rem_mem[rd_addr];
                lane_rd_reg.rem_sign  <= sign_mem[rd_addr];
            end
        end

        assign lane_rd[l] = lane_rd_reg;
    end

endmodule

// ===== design/mcr_lane.sv =====
// ----------------------------------------------------------------------------
// Ramp channel update
// One channel's step, remainder carry and Q15 saturation, or its final value, for a single tick.
// ----------------------------------------------------------------------------
module mcr_lane (
    input  mcr_pkg::lane_rd_t  lane_rd,
    input  logic signed [15:0] cur_val,
    input  logic [31:0]        cur_acc,
    input  logic [31:0]        ramp,
    input  logic               at_final,
    output logic signed [15:0] val_out,
    output logic [31:0]        acc_out
);

    logic signed [33:0] sum;
    logic [31:0]        acc_c;
    logic [31:0]        left;
    logic               carry_en;
    logic               carry;
    logic signed [15:0] sat_val;

    always_comb
    begin
        carry_en = (lane_rd.rem != 32'd0) && (lane_rd.rem_sign != 2'sd0);
        acc_c    = (cur_acc >= ramp) ? 32'd0 : cur_acc;
        left     = ramp - acc_c;
        carry    = carry_en && (lane_rd.rem >= left);
        sum      = 34'(cur_val) + 34'(lane_rd.step);
        if (carry)
        begin
            sum = sum + 34'(lane_rd.rem_sign);
        end
        if (sum > 34'sd32767)
        begin
            sat_val = 16'sh7FFF;
        end
        else if (sum < -34'sd32768)
        begin
            sat_val = 16'sh8000;
        end
        else
        begin
            sat_val = sum[15:0];
        end

        if (at_final)
        begin
            val_out = lane_rd.final_val;
            acc_out = cur_acc;
        end
        else
        begin
            val_out = sat_val;
            if (!carry_en)
            begin
                acc_out = cur_acc;
            end
            else if (carry)
            begin
                acc_out = lane_rd.rem - left;
            end
            else
            begin
                acc_out = acc_c + lane_rd.rem;
            end
        end
    end

endmodule

// ===== tb/sv/multi_phase_current_ramp_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-phase current ramp generator testbench
// The phase table is loaded through the request stream and the phase count
// is set over APB while the block is idle. A directed part and a random part
// then run tick sequences through the profile. A behavioral profile model
// predicts every output word, and the monitor checks each word field by field.
// ----------------------------------------------------------------------------
module multi_phase_current_ramp_tb;

    localparam int PHASES = 8;
    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES = 48;
    localparam int RANDOM_ITEMS = 970;
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [3:0] FS_NONE = 4'd15;
    localparam logic [2:0] ADDR_PHASE_COUNT = 3'd0;

    typedef struct {
        logic [1:0]  req;
        logic [2:0]  entry;
        logic [3:0]  sel;
        logic [31:0] value;
    } request_t;

    typedef struct {
        logic [15:0] speed;
        logic [15:0] id;
        logic [15:0] iq;
        logic        valid;
        logic        done;
        logic [2:0]  phase;
    } setpoint_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    multi_phase_current_ramp #(
        .MAX_PHASES(PHASES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    request_t  requests_pending[$];
    setpoint_t setpoints_due[$];
    request_t  next_word;
    setpoint_t want;

    int  errors = 0;
    int  cycles = 0;
    int  items_issued = 0;
    int  holds_asked = 0;
    int  holds_served = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    bit  quiet_tail = 1'b0;
    bit  word_taken = 1'b0;

    // Profile model state.
    logic [3:0]         phase_cfg = '0;
    logic [2:0]         phase_at = '0;
    bit                 phase_begun = 1'b0;
    bit                 profile_done = 1'b0;
    logic [31:0]        tick_in_phase = '0;
    logic signed [15:0] lane_val[mcr_pkg::LANES];
    logic [31:0]        lane_acc[mcr_pkg::LANES];
    bit                 kind_tab[PHASES];
    logic [31:0]        ramp_tab[PHASES];
    logic [31:0]        hold_tab[PHASES];
    logic signed [15:0] final_tab[PHASES*mcr_pkg::LANES];
    logic signed [31:0] step_tab[PHASES*mcr_pkg::LANES];
    logic [31:0]        rem_tab[PHASES*mcr_pkg::LANES];
    logic signed [1:0]  sign_tab[PHASES*mcr_pkg::LANES];

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic signed [15:0] ramp_lane(input int lane, input int slot,
                                                     input logic [31:0] ramp_len);
        longint      nxt;
        logic [31:0] left;
        nxt = longint'(lane_val[lane]) + longint'(step_tab[slot]);
        if (rem_tab[slot] != 0 && sign_tab[slot] != 0)
        begin
            if (lane_acc[lane] >= ramp_len)
                lane_acc[lane] = '0;
            left = ramp_len - lane_acc[lane];
            if (rem_tab[slot] >= left)
            begin
                lane_acc[lane] = rem_tab[slot] - left;
                nxt = nxt + longint'(sign_tab[slot]);
            end
            else
                lane_acc[lane] = lane_acc[lane] + rem_tab[slot];
        end
        if (nxt > 32767)
            return 16'sh7FFF;
        if (nxt < -32768)
            return -16'sh8000;
        return nxt[15:0];
    endfunction

    task automatic clear_profile();
        phase_at = '0;
        phase_begun = 1'b0;
        profile_done = 1'b0;
        tick_in_phase = '0;
        for (int k = 0; k < mcr_pkg::LANES; k++)
        begin
            lane_val[k] = '0;
            lane_acc[k] = '0;
        end
    endtask

    task automatic store_field(input logic [2:0] entry, input logic [3:0] sel,
                               input logic [31:0] value);
        int e;
        e = int'(entry);
        if (sel == mcr_pkg::FS_KIND)
            kind_tab[e] = value[0];
        else if (sel == mcr_pkg::FS_RAMP)
            ramp_tab[e] = value;
        else if (sel == mcr_pkg::FS_HOLD)
            hold_tab[e] = value;
        else if (sel < mcr_pkg::FS_STEP)
            final_tab[e*mcr_pkg::LANES + int'(sel - mcr_pkg::FS_FINAL)] = value[15:0];
        else if (sel < mcr_pkg::FS_REM)
            step_tab[e*mcr_pkg::LANES + int'(sel - mcr_pkg::FS_STEP)] = value;
        else if (sel < mcr_pkg::FS_SIGN)
            rem_tab[e*mcr_pkg::LANES + int'(sel - mcr_pkg::FS_REM)] = value;
        else if (sel <= mcr_pkg::FS_LAST)
            sign_tab[e*mcr_pkg::LANES + int'(sel - mcr_pkg::FS_SIGN)] = value[1:0];
    endtask

    task automatic advance_profile(input logic [1:0] req, input logic [2:0] entry,
                                   input logic [3:0] sel, input logic [31:0] value);
        int          count;
        int          p;
        logic [31:0] ramp_len;
        logic [31:0] hold_len;
        logic [31:0] total;
        setpoint_t   sp;
        if (req == mcr_pkg::REQ_WRITE)
            store_field(entry, sel, value);
        else if (req == mcr_pkg::REQ_RESTART)
            clear_profile();
        else if (req == mcr_pkg::REQ_TICK)
        begin
            count = (phase_cfg > PHASES) ? PHASES : int'(phase_cfg);
            if (count != 0)
            begin
                if (phase_at >= count)
                    phase_at = 3'(count - 1);
                if (!phase_begun)
                begin
                    phase_begun = 1'b1;
                    tick_in_phase = '0;
                    profile_done = 1'b0;
                    for (int k = 0; k < mcr_pkg::LANES; k++)
                        lane_acc[k] = '0;
                end
                p = int'(phase_at);
                ramp_len = (ramp_tab[p] == 0) ? 32'd1 : ramp_tab[p];
                hold_len = kind_tab[p] ? hold_tab[p] : 32'd0;
                total = (mcr_pkg::TICK_CAP - ramp_len < hold_len) ? mcr_pkg::TICK_CAP
                                                                  : ramp_len + hold_len;
                if (tick_in_phase < total)
                    tick_in_phase = tick_in_phase + 32'd1;
                for (int k = 0; k < mcr_pkg::LANES; k++)
                begin
                    if (tick_in_phase >= ramp_len)
                        lane_val[k] = final_tab[p*mcr_pkg::LANES + k];
                    else
                        lane_val[k] = ramp_lane(k, p*mcr_pkg::LANES + k, ramp_len);
                end
                if (tick_in_phase >= total)
                begin
                    if (p + 1 < count)
                    begin
                        phase_at = 3'(p + 1);
                        tick_in_phase = '0;
                        for (int k = 0; k < mcr_pkg::LANES; k++)
                            lane_acc[k] = '0;
                    end
                    else
                        profile_done = 1'b1;
                end
            end
            sp.speed = lane_val[0];
            sp.id = lane_val[1];
            sp.iq = lane_val[2];
            sp.valid = (count != 0);
            sp.done = profile_done;
            sp.phase = phase_at;
            setpoints_due.push_back(sp);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] expected,
                                 input logic [15:0] actual);
        if (actual !== expected)
        begin
            $display("%0t ns: %s expected %h got %h", $time, name, expected, actual);
            errors++;
        end
    endtask

    // Input side: the model advances on every accepted word; output side: check.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("multi_phase_current_ramp test failed");
            $finish;
        end
        else
        begin
            word_taken = rst_n && s_tvalid && s_tready;
            if (word_taken)
                advance_profile(s_tuser, s_tdata[2:0], s_tdata[6:3], s_tdata[38:7]);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (setpoints_due.size() == 0)
                begin
                    $display("%0t ns: output word with no expected setpoint, got %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = setpoints_due.pop_front();
                    compare_field("speed_cmd", want.speed, m_tdata[15:0]);
                    compare_field("id_cmd", want.id, m_tdata[31:16]);
                    compare_field("iq_cmd", want.iq, m_tdata[47:32]);
                    compare_field("phase_now", 16'(want.phase), 16'(m_tdata[50:48]));
                    compare_field("profile_valid", 16'(want.valid), 16'(m_tuser[0]));
                    compare_field("profile_done", 16'(want.done), 16'(m_tuser[1]));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (word_taken || !s_tvalid))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (requests_pending.size() != 0)
            begin
                next_word = requests_pending.pop_front();
                s_tdata <= {1'b0, next_word.value, next_word.sel, next_word.entry};
                s_tuser <= next_word.req;
                s_tvalid <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 4) == 0)
                    tx_gap = $urandom_range(1, 3);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (holds_served != holds_asked)
        begin
            holds_served++;
            rx_gap = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            rx_gap = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic put_request(input logic [1:0] req, input logic [2:0] entry,
                               input logic [3:0] sel, input logic [31:0] value);
        request_t r;
        r.req = req;
        r.entry = entry;
        r.sel = sel;
        r.value = value;
        requests_pending.push_back(r);
        if (req != REQ_NONE)
            items_issued++;
    endtask

    task automatic put_tick();
        put_request(mcr_pkg::REQ_TICK, 3'($urandom), 4'($urandom), $urandom);
    endtask

    task automatic put_restart();
        put_request(mcr_pkg::REQ_RESTART, 3'($urandom), 4'($urandom), $urandom);
    endtask

    // Lengths stay short so that profiles run through to done; now and then
    // a huge value exercises the tick counter cap.
    function automatic logic [31:0] field_word(input logic [3:0] sel);
        int r;
        r = $urandom_range(0, 99);
        if (sel == mcr_pkg::FS_RAMP)
            return (r == 0) ? $urandom : 32'($urandom_range(0, 12));
        if (sel == mcr_pkg::FS_HOLD)
            return (r < 2) ? $urandom : 32'($urandom_range(0, 10));
        if (sel >= mcr_pkg::FS_STEP && sel < mcr_pkg::FS_REM)
            return (r < 25) ? $urandom : 32'($urandom_range(0, 4000)) - 32'd2000;
        if (sel >= mcr_pkg::FS_REM && sel < mcr_pkg::FS_SIGN)
            return (r < 30) ? 32'd0 : (r < 65) ? 32'($urandom_range(1, 20)) : $urandom;
        return $urandom;
    endfunction

    task automatic load_entry(input logic [2:0] e, input logic kind,
                              input logic [31:0] ramp_len, input logic [31:0] hold_len);
        put_request(mcr_pkg::REQ_WRITE, e, mcr_pkg::FS_KIND, {31'($urandom), kind});
        put_request(mcr_pkg::REQ_WRITE, e, mcr_pkg::FS_RAMP, ramp_len);
        put_request(mcr_pkg::REQ_WRITE, e, mcr_pkg::FS_HOLD, hold_len);
        for (int k = 0; k < mcr_pkg::LANES; k++)
        begin
            put_request(mcr_pkg::REQ_WRITE, e, mcr_pkg::FS_FINAL + 4'(k),
                        field_word(mcr_pkg::FS_FINAL));
            put_request(mcr_pkg::REQ_WRITE, e, mcr_pkg::FS_STEP + 4'(k),
                        field_word(mcr_pkg::FS_STEP));
            put_request(mcr_pkg::REQ_WRITE, e, mcr_pkg::FS_REM + 4'(k),
                        field_word(mcr_pkg::FS_REM));
            put_request(mcr_pkg::REQ_WRITE, e, mcr_pkg::FS_SIGN + 4'(k),
                        field_word(mcr_pkg::FS_SIGN));
        end
    endtask

    task automatic put_lane_fields(input logic [2:0] e, input logic [3:0] base,
                                   input logic [31:0] value);
        for (int k = 0; k < mcr_pkg::LANES; k++)
            put_request(mcr_pkg::REQ_WRITE, e, base + 4'(k), value);
    endtask

    task automatic wait_idle();
        while (requests_pending.size() != 0 || s_tvalid || setpoints_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_phase_count(input logic [3:0] count);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PHASE_COUNT;
        pwdata <= {28'd0, count};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        phase_cfg = count;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [3:0] pick_phase_count();
        int r;
        r = $urandom_range(0, 11);
        if (r <= PHASES)
            return 4'(r);
        return 4'($urandom_range(PHASES + 1, 15));
    endfunction

    initial
    begin
        int segment;
        int r;
        logic [3:0] sel;
        clear_profile();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_entry(3'd0, 1'b0, 32'd0, 32'd5);
        load_entry(3'd1, 1'b1, 32'd2, 32'd3);
        load_entry(3'd2, 1'b0, 32'd3, 32'd0);
        put_lane_fields(3'd2, mcr_pkg::FS_STEP, 32'h7FFF_FFFF);
        load_entry(3'd3, 1'b0, 32'd3, 32'd0);
        put_lane_fields(3'd3, mcr_pkg::FS_STEP, 32'h8000_0000);
        load_entry(3'd4, 1'b0, 32'd6, 32'd0);
        put_lane_fields(3'd4, mcr_pkg::FS_REM, 32'hFFFF_FFFF);
        put_lane_fields(3'd4, mcr_pkg::FS_SIGN, 32'h0000_0002);
        load_entry(3'd5, 1'b1, 32'd4, 32'd0);
        put_lane_fields(3'd5, mcr_pkg::FS_REM, 32'd0);
        put_lane_fields(3'd5, mcr_pkg::FS_SIGN, 32'd1);
        load_entry(3'd6, 1'b0, 32'd5, 32'd0);
        put_lane_fields(3'd6, mcr_pkg::FS_REM, 32'd3);
        put_lane_fields(3'd6, mcr_pkg::FS_SIGN, 32'd0);
        load_entry(3'd7, 1'b1, 32'd1, 32'd2);

        // With no phases configured, ticks only report the held values.
        put_tick();
        put_tick();
        put_request(mcr_pkg::REQ_WRITE, 3'd0, FS_NONE, $urandom);
        put_request(REQ_NONE, 3'($urandom), 4'($urandom), $urandom);
        wait_idle();
        write_phase_count(4'd8);

        holds_asked++;
        repeat (34) put_tick();
        put_restart();
        repeat (3) put_tick();

        // Ramp and hold at their maximum: the phase total hits the cap.
        put_request(mcr_pkg::REQ_WRITE, 3'd0, mcr_pkg::FS_KIND, 32'd1);
        put_request(mcr_pkg::REQ_WRITE, 3'd0, mcr_pkg::FS_RAMP, 32'hFFFF_FFFF);
        put_request(mcr_pkg::REQ_WRITE, 3'd0, mcr_pkg::FS_HOLD, 32'hFFFF_FFFF);
        put_restart();
        repeat (3) put_tick();
        put_request(mcr_pkg::REQ_WRITE, 3'd0, mcr_pkg::FS_RAMP, 32'd2);
        put_request(mcr_pkg::REQ_WRITE, 3'd0, mcr_pkg::FS_HOLD, 32'd1);
        wait_idle();

        segment = 0;
        while (items_issued < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                write_phase_count(pick_phase_count());
            end
            repeat ($urandom_range(0, 3))
                load_entry(3'($urandom), 1'($urandom), field_word(mcr_pkg::FS_RAMP),
                           field_word(mcr_pkg::FS_HOLD));
            if ($urandom_range(0, 2) != 0)
                put_restart();
            if (segment % 7 == 3)
                holds_asked++;
            repeat ($urandom_range(10, 80))
            begin
                put_tick();
                r = $urandom_range(0, 29);
                if (r == 0)
                begin
                    sel = 4'($urandom);
                    put_request(mcr_pkg::REQ_WRITE, 3'($urandom), sel, field_word(sel));
                end
                else if (r == 1)
                    put_request(REQ_NONE, 3'($urandom), 4'($urandom), $urandom);
                else if (r == 2)
                    put_restart();
            end
            if (segment % 5 == 2)
                wait_idle();
            segment++;
        end

        wait_idle();
        write_phase_count(4'd8);
        quiet_tail = 1'b1;
        put_restart();
        repeat (40) put_tick();

        while (requests_pending.size() != 0 || s_tvalid || setpoints_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("multi_phase_current_ramp test passed");
        else
            $display("multi_phase_current_ramp test failed");
        $finish;
    end

endmodule
